// ----- src/free_block_table_coalescer_defines.svh -----
// assertion macros shared by the free block table checker
// no dependencies; included by files that carry concurrent assertions
`ifndef FREE_BLOCK_TABLE_COALESCER_DEFINES_SVH
`define FREE_BLOCK_TABLE_COALESCER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FBTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define FBTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/fbtc_pkg.sv -----
// shared types and constants of the free block table coalescer
// no dependencies; imported by the controller, datapath, top level and checker
package fbtc_pkg;

	localparam int FBTC_SLOT_W    = 3;
	localparam int FBTC_FIELD_W   = 16;
	localparam int FBTC_ADDR_BITS = 16;
	localparam int FBTC_TDATA_W   = 40;
	localparam int FBTC_FUNC_W    = 2;
	localparam int FBTC_STATUS_W  = 3;
	localparam int FBTC_VALID_BIT = FBTC_SLOT_W + 2 * FBTC_FIELD_W;

	// one past the highest address a released region may reach
	localparam logic [32:0] FBTC_ADDR_LIMIT = 33'd1 << FBTC_ADDR_BITS;

	typedef enum logic [1:0] {
		FN_WRITE   = 2'd0,
		FN_READ    = 2'd1,
		FN_RELEASE = 2'd2,
		FN_REORDER = 2'd3
	} fbtc_func_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UPPER  = 3'd1,
		ST_BOTH   = 3'd2,
		ST_LOWER  = 3'd3,
		ST_INSERT = 3'd4,
		ST_FULL   = 3'd5,
		ST_RANGE  = 3'd6
	} fbtc_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_TAIL,
		S_SORT_START,
		S_SORT_LOAD,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_PUT,
		S_SORT_END,
		S_FINISH
	} fbtc_state_t;

	// controller to datapath
	typedef struct packed {
		logic req_load;    // capture the accepted item
		logic rd_en;       // read one table entry
		logic rd_req;      // read address is the item's slot
		logic scan_clr;    // clear neighbor search
		logic scan_eval;   // fold last read entry into the search
		logic carry_load;  // load sort carry from read data
		logic sort_cmp;    // compare-swap carry against read data
		logic sort_put;    // store carry at end of pass
		logic commit;      // apply update and load the result register
	} fbtc_cmd_t;

	// datapath to controller
	typedef struct packed {
		fbtc_func_t func;
		logic       bad;       // slot or region out of range, or zero region size
		logic       out_free;  // result register can take a result
	} fbtc_sts_t;

endpackage

// ----- src/fbtc_ctrl.sv -----
// sequencer of the free block table coalescer: decode, scan, sort and finish
// depends on fbtc_pkg
module fbtc_ctrl
	import fbtc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  fbtc_sts_t                        sts,
	output fbtc_cmd_t                        cmd,
	output logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
	output logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

	fbtc_state_t      state_q, state_d;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] end_q;
	logic [IDX_W-1:0] cnt_inc;

	assign cnt_inc = cnt_q + ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			end_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					cnt_q <= '0;
					end_q <= LAST;
				end
				S_SCAN:       cnt_q <= cnt_inc;
				S_SORT_START: cnt_q <= '0;
				S_SORT_CMP:   cnt_q <= cnt_inc;
				S_SORT_PUT:   end_q <= end_q - ONE;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (sts.bad) begin
					state_d = S_FINISH;
				end else begin
					case (sts.func)
						FN_RELEASE: state_d = S_SCAN;
						FN_REORDER: state_d = S_SORT_START;
						default:    state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST) state_d = S_SCAN_TAIL;
			end
			S_SCAN_TAIL:  state_d = S_FINISH;
			S_SORT_START: state_d = S_SORT_LOAD;
			S_SORT_LOAD:  state_d = S_SORT_CMP;
			S_SORT_RD:    state_d = S_SORT_CMP;
			S_SORT_CMP: begin
				state_d = (cnt_inc == end_q) ? S_SORT_PUT : S_SORT_RD;
			end
			S_SORT_PUT: begin
				state_d = (end_q == ONE) ? S_SORT_END : S_SORT_START;
			end
			S_SORT_END: state_d = S_FINISH;
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		rd_idx   = cnt_q;
		wr_idx   = cnt_q;
		case (state_q)
			S_IDLE: begin
				s_tready     = 1'b1;
				cmd.req_load = s_tvalid;
			end
			S_DECODE: begin
				cmd.scan_clr = 1'b1;
				if (sts.func == FN_READ && !sts.bad) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_req = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.rd_en     = 1'b1;
				cmd.scan_eval = 1'b1;
			end
			S_SCAN_TAIL: cmd.scan_eval = 1'b1;
			S_SORT_START: begin
				cmd.rd_en = 1'b1;
				rd_idx    = '0;
			end
			S_SORT_LOAD: begin
				cmd.carry_load = 1'b1;
				cmd.rd_en      = 1'b1;
				rd_idx         = cnt_inc;
			end
			S_SORT_RD: begin
				cmd.rd_en = 1'b1;
				rd_idx    = cnt_inc;
			end
			S_SORT_CMP: cmd.sort_cmp = 1'b1;
			S_SORT_PUT: begin
				cmd.sort_put = 1'b1;
				wr_idx       = end_q;
			end
			S_SORT_END: begin
				cmd.rd_en = 1'b1;
				rd_idx    = '0;
			end
			S_FINISH: cmd.commit = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- src/fbtc_dp.sv -----
// datapath of the free block table coalescer: table storage, neighbor search,
// sort carry, update logic and result register; depends on fbtc_pkg
module fbtc_dp
	import fbtc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [FBTC_TDATA_W-1:0]          s_tdata,
	input  logic [FBTC_FUNC_W-1:0]           s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [FBTC_TDATA_W-1:0]          m_tdata,
	output logic [FBTC_STATUS_W-1:0]         m_tuser,
	input  fbtc_cmd_t                        cmd,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_idx,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
	output fbtc_sts_t                        sts
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int FW     = FBTC_FIELD_W;
	localparam int WORD_W = 2 * FW;
	localparam int PAD_W  = FBTC_TDATA_W - FBTC_VALID_BIT - 1;
	localparam logic [FW+1:0] SAT_MAX = {2'b00, {FW{1'b1}}};

	function automatic logic [FW-1:0] sat_size(input logic [FW+1:0] v);
		return (v > SAT_MAX) ? {FW{1'b1}} : v[FW-1:0];
	endfunction

	// captured item
	fbtc_func_t             req_func_q;
	logic [FBTC_SLOT_W-1:0] req_slot_q;
	logic [FW-1:0]          req_start_q;
	logic [FW-1:0]          req_size_q;
	logic                   req_valid_q;

	// table: words are {size, start}
	logic [WORD_W-1:0]        mem_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] written_q;

	logic [WORD_W-1:0] rd_data_q;
	logic              rd_valid_q;
	logic              rd_written_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic              rd_vld_q;

	logic             up_found_q, lo_found_q, emp_found_q;
	logic [IDX_W-1:0] up_idx_q, lo_idx_q, emp_idx_q;
	logic [FW-1:0]    up_size_q, lo_start_q, lo_size_q;

	logic [WORD_W-1:0] carry_q;
	logic              carry_valid_q;

	logic                   out_valid_q;
	fbtc_status_t           out_status_q;
	logic [FBTC_SLOT_W-1:0] out_slot_q;
	logic [FW-1:0]          out_start_q, out_size_q;
	logic                   out_entry_valid_q;

	logic             slot_oob, range_bad, bad;
	logic [IDX_W-1:0] slot_idx, rd_addr;
	logic [FW:0]      req_end;
	logic [FW-1:0]    rd_start, rd_size;
	logic [FW:0]      rd_end;
	logic             up_hit, lo_hit, emp_hit, do_eval;
	logic             swap;

	fbtc_status_t  res_status;
	logic [IDX_W-1:0] res_idx;
	logic [FW-1:0] res_start, res_size;
	logic          res_valid, res_write;

	logic              wr_en, clr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_word;
	logic              wr_vbit;

	// request checks
	assign slot_oob  = {29'd0, req_slot_q} >= 32'(TABLE_ENTRIES);
	assign slot_idx  = IDX_W'({29'd0, req_slot_q});
	assign req_end   = {1'b0, req_start_q} + {1'b0, req_size_q};
	assign range_bad = (req_size_q == '0) || ({16'd0, req_end} > FBTC_ADDR_LIMIT);

	always_comb begin
		case (req_func_q)
			FN_WRITE, FN_READ: bad = slot_oob;
			FN_RELEASE:        bad = range_bad;
			default:           bad = 1'b0;
		endcase
	end

	assign sts.func     = req_func_q;
	assign sts.bad      = bad;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_func_q  <= fbtc_func_t'(s_tuser);
			req_slot_q  <= s_tdata[FBTC_SLOT_W-1:0];
			req_start_q <= s_tdata[FBTC_SLOT_W +: FW];
			req_size_q  <= s_tdata[FBTC_SLOT_W+FW +: FW];
			req_valid_q <= s_tdata[FBTC_VALID_BIT];
		end
	end

	// table read port, registered; never-written entries read as zero
	assign rd_addr  = cmd.rd_req ? slot_idx : rd_idx;
	assign rd_start = rd_written_q ? rd_data_q[FW-1:0] : '0;
	assign rd_size  = rd_written_q ? rd_data_q[WORD_W-1:FW] : '0;
	assign rd_end   = {1'b0, rd_start} + {1'b0, rd_size};

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q    <= mem_q[rd_addr];
			rd_valid_q   <= valid_q[rd_addr];
			rd_written_q <= written_q[rd_addr];
			rd_idx_q     <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_q <= 1'b0;
		else         rd_vld_q <= cmd.rd_en;
	end

	// neighbor and empty slot search, first match wins
	assign do_eval = cmd.scan_eval && rd_vld_q;
	assign up_hit  = rd_valid_q && !up_found_q && ({1'b0, rd_start} == req_end);
	assign lo_hit  = rd_valid_q && !lo_found_q && (rd_end == {1'b0, req_start_q});
	assign emp_hit = !rd_valid_q && !emp_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_found_q  <= 1'b0;
			lo_found_q  <= 1'b0;
			emp_found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			up_found_q  <= 1'b0;
			lo_found_q  <= 1'b0;
			emp_found_q <= 1'b0;
		end else if (do_eval) begin
			if (up_hit)  up_found_q  <= 1'b1;
			if (lo_hit)  lo_found_q  <= 1'b1;
			if (emp_hit) emp_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_eval) begin
			if (up_hit) begin
				up_idx_q  <= rd_idx_q;
				up_size_q <= rd_size;
			end
			if (lo_hit) begin
				lo_idx_q   <= rd_idx_q;
				lo_start_q <= rd_start;
				lo_size_q  <= rd_size;
			end
			if (emp_hit) emp_idx_q <= rd_idx_q;
		end
	end

	// sort key: valid entries first, then ascending size
	assign swap = {~carry_valid_q, carry_q[WORD_W-1:FW]} > {~rd_valid_q, rd_size};

	always_ff @(posedge clk) begin
		if (cmd.carry_load || (cmd.sort_cmp && !swap)) begin
			carry_q       <= {rd_size, rd_start};
			carry_valid_q <= rd_valid_q;
		end
	end

	// result of the current item, also the entry written on commit
	always_comb begin
		res_status = ST_OK;
		res_idx    = '0;
		res_start  = '0;
		res_size   = '0;
		res_valid  = 1'b0;
		res_write  = 1'b0;
		if (bad) begin
			res_status = ST_RANGE;
		end else begin
			case (req_func_q)
				FN_WRITE: begin
					res_idx   = slot_idx;
					res_start = req_start_q;
					res_size  = req_size_q;
					res_valid = req_valid_q;
					res_write = 1'b1;
				end
				FN_READ, FN_REORDER: begin
					res_idx   = rd_idx_q;
					res_start = rd_start;
					res_size  = rd_size;
					res_valid = rd_valid_q;
				end
				FN_RELEASE: begin
					res_valid = 1'b1;
					res_write = 1'b1;
					if (up_found_q && lo_found_q) begin
						res_status = ST_BOTH;
						res_idx    = lo_idx_q;
						res_start  = lo_start_q;
						res_size   = sat_size({2'b00, lo_size_q} + {2'b00, req_size_q}
							+ {2'b00, up_size_q});
					end else if (up_found_q) begin
						res_status = ST_UPPER;
						res_idx    = up_idx_q;
						res_start  = req_start_q;
						res_size   = sat_size({2'b00, up_size_q} + {2'b00, req_size_q});
					end else if (lo_found_q) begin
						res_status = ST_LOWER;
						res_idx    = lo_idx_q;
						res_start  = lo_start_q;
						res_size   = sat_size({2'b00, lo_size_q} + {2'b00, req_size_q});
					end else if (emp_found_q) begin
						res_status = ST_INSERT;
						res_idx    = emp_idx_q;
						res_start  = req_start_q;
						res_size   = req_size_q;
					end else begin
						res_status = ST_FULL;
						res_valid  = 1'b0;
						res_write  = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// table write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_idx;
		wr_word = carry_q;
		wr_vbit = carry_valid_q;
		clr_en  = 1'b0;
		if (cmd.sort_cmp) begin
			wr_en = 1'b1;
			if (swap) begin
				wr_word = {rd_size, rd_start};
				wr_vbit = rd_valid_q;
			end
		end else if (cmd.sort_put) begin
			wr_en = 1'b1;
		end else if (cmd.commit) begin
			wr_en   = res_write;
			wr_addr = res_idx;
			wr_word = {res_size, res_start};
			wr_vbit = res_valid;
			clr_en  = res_write && (res_status == ST_BOTH);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			written_q <= '0;
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (wr_en && wr_addr == IDX_W'(i)) begin
					valid_q[i]   <= wr_vbit;
					written_q[i] <= 1'b1;
				end else if (clr_en && up_idx_q == IDX_W'(i)) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (m_tready)   out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q      <= res_status;
			out_slot_q        <= FBTC_SLOT_W'(res_idx);
			out_start_q       <= res_start;
			out_size_q        <= res_size;
			out_entry_valid_q <= res_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_entry_valid_q, out_size_q, out_start_q, out_slot_q};

endmodule

// ----- src/free_block_table_coalescer.sv -----
// free block table coalescer: write, read, release with merge, and reorder
// a result is registered as the sequencer returns to idle; one item is worked at a time
// release time is set by the table scan, one read a cycle; reorder by the compare-swap passes
// arst_n clears the table to all zero (empty) and empties the result register
// depends on fbtc_pkg, fbtc_ctrl, fbtc_dp
module free_block_table_coalescer
	import fbtc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request items
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [FBTC_TDATA_W-1:0]  s_tdata,   // slot[2:0], region_start[18:3],
	                                            // region_size[34:19], entry_valid_in[35]
	input  logic [FBTC_FUNC_W-1:0]   s_tuser,   // func[1:0]
	// result items
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [FBTC_TDATA_W-1:0]  m_tdata,   // touched_slot[2:0], entry_start[18:3],
	                                            // entry_size[34:19], entry_valid[35]
	output logic [FBTC_STATUS_W-1:0] m_tuser    // status[2:0]
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	fbtc_cmd_t        cmd;
	fbtc_sts_t        sts;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;

	// sequencer: one item at a time, idle state is the only accepting state
	fbtc_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx)
	);

	// table, search, sort carry and result register
	fbtc_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.sts      (sts)
	);

endmodule

// ----- src/fbtc_checker.sv -----
// port-level checks of the free block table coalescer, bound to the top level
// depends on fbtc_pkg and free_block_table_coalescer_defines.svh
`include "free_block_table_coalescer_defines.svh"

module fbtc_checker
	import fbtc_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [FBTC_TDATA_W-1:0]  m_tdata,
	input logic [FBTC_STATUS_W-1:0] m_tuser
);

	// a waiting result holds its value
	`FBTC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// one item in flight: no accept in the cycle after an accept
	`FBTC_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "item taken while busy")

	// rejected items report no entry
	`FBTC_ASSERT_SAME(a_reject_zero, clk, arst_n, m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_RANGE), m_tdata == '0, "reject result carries entry data")

	// merges and inserts always leave a free block in the reported entry
	`FBTC_ASSERT_SAME(a_merge_valid, clk, arst_n, m_tvalid && (m_tuser == ST_UPPER || m_tuser == ST_BOTH || m_tuser == ST_LOWER || m_tuser == ST_INSERT), m_tdata[FBTC_VALID_BIT], "merged entry not marked free")

endmodule

bind free_block_table_coalescer fbtc_checker u_fbtc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
